### sv/wcht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wcht_pkg;

  // Fixed field widths of the stream words.
  localparam int OP_W        = 2;
  localparam int KEY_W       = 64;
  localparam int LEN_W       = 4;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 8;
  localparam int OCC_W       = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  // Hash constants: base 31, each byte biased so that 'a' maps to 1.
  localparam int         HASH_BASE  = 31;
  localparam int         CHAR_BIAS  = 96;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_SEARCH,
    OP_DELETE,
    OP_CLEAR
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_FULL,
    ST_EMPTY
  } status_t;

endpackage

`default_nettype wire

### sv/wcht_modadd.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-operand adder modulo the table size. All operands are below the
// modulus, so the sum is below three times it and one of two subtractions
// brings it back into range.
module wcht_modadd #(
  parameter int TABLE_SIZE = 256,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic [IW-1:0] a,
  input  logic [IW-1:0] b,
  input  logic [IW-1:0] c,
  output logic [IW-1:0] y
);

  localparam logic [IW+1:0] MOD1 = (IW+2)'(TABLE_SIZE);
  localparam logic [IW+1:0] MOD2 = (IW+2)'(2 * TABLE_SIZE);

  logic [IW+1:0] sum;

  always_comb begin
    sum = (IW+2)'(a) + (IW+2)'(b) + (IW+2)'(c);
    priority if (sum >= MOD2) begin
      y = IW'(sum - MOD2);
    end else if (sum >= MOD1) begin
      y = IW'(sum - MOD1);
    end else begin
      y = IW'(sum);
    end
  end

endmodule

`default_nettype wire

### sv/wcht_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// Home slot sequencer. Each non-space byte is multiplied by its power of 31
// bit-serially (MSB first, doubling through the shared modular adder), then
// folded into the running hash together with the constant for the -96 bias.
module wcht_hash
  import wcht_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_BYTES  = 8,
  localparam int IW = $clog2(TABLE_SIZE),
  localparam int KW = KEY_BYTES * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KW-1:0]    key,
  input  logic [LEN_W-1:0] key_len,
  output logic             done,
  output logic [IW-1:0]    home
);

  localparam int CNT_W = $clog2(KEY_BYTES + 1);
  localparam int IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  typedef enum logic [1:0] {
    H_IDLE,
    H_BYTE,
    H_BIT,
    H_FOLD
  } hstate_t;

  hstate_t          state_r;
  logic [KW-1:0]    key_r;
  logic [LEN_W-1:0] len_r;
  logic [CNT_W-1:0] byte_r;
  logic [CNT_W-1:0] term_r;
  logic [2:0]       bit_r;
  logic [IW-1:0]    acc_r;
  logic [IW-1:0]    hash_r;
  logic             done_r;

  logic [IW-1:0] pw_tbl [KEY_BYTES];
  logic [IW-1:0] bias_tbl [KEY_BYTES];
  logic [7:0]    cur_byte;
  logic [IW-1:0] add_a;
  logic [IW-1:0] add_b;
  logic [IW-1:0] add_c;
  logic [IW-1:0] add_y;

  // Powers of 31 and the matching bias terms, both reduced modulo the table
  // size at elaboration.
  for (genvar g = 0; g < KEY_BYTES; g++) begin : g_tbl
    localparam longint unsigned PWJ  = (longint'(HASH_BASE) ** g) % TABLE_SIZE;
    localparam longint unsigned BIAS =
      (TABLE_SIZE - (CHAR_BIAS * PWJ) % TABLE_SIZE) % TABLE_SIZE;
    assign pw_tbl[g]   = IW'(PWJ);
    assign bias_tbl[g] = IW'(BIAS);
  end

  assign cur_byte = key_r[byte_r[IDX_W-1:0]*8 +: 8];

  always_comb begin
    if (state_r == H_FOLD) begin
      add_a = hash_r;
      add_b = acc_r;
      add_c = bias_tbl[term_r[IDX_W-1:0]];
    end else begin
      add_a = acc_r;
      add_b = acc_r;
      add_c = cur_byte[bit_r] ? pw_tbl[term_r[IDX_W-1:0]] : '0;
    end
  end

  wcht_modadd #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_modadd (
    .a(add_a),
    .b(add_b),
    .c(add_c),
    .y(add_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == H_BYTE) && (LEN_W'(byte_r) == len_r);
      unique case (state_r)
        H_IDLE: begin
          if (start) begin
            key_r   <= key;
            len_r   <= key_len;
            byte_r  <= '0;
            term_r  <= '0;
            hash_r  <= '0;
            state_r <= H_BYTE;
          end
        end
        H_BYTE: begin
          priority if (LEN_W'(byte_r) == len_r) begin
            state_r <= H_IDLE;
          end else if (cur_byte == SPACE_CHAR) begin
            byte_r <= byte_r + CNT_W'(1);
          end else begin
            acc_r   <= '0;
            bit_r   <= 3'd7;
            state_r <= H_BIT;
          end
        end
        H_BIT: begin
          acc_r <= add_y;
          if (bit_r == 3'd0) begin
            state_r <= H_FOLD;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        H_FOLD: begin
          hash_r  <= add_y;
          byte_r  <= byte_r + CNT_W'(1);
          term_r  <= term_r + CNT_W'(1);
          state_r <= H_BYTE;
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign home = hash_r;

endmodule

`default_nettype wire

### sv/word_count_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Word counting hash table with linear probing. Each input word carries an
// operation in in_tuser (insert, search, delete, clear) and a key of up to
// KEY_BYTES bytes with its length in in_tdata; each one yields exactly one
// output word with a status in out_tuser and the slot and count in out_tdata.
// The block handles one word at a time and is not ready while it works. A
// lookup first computes the home slot bit-serially, byte by byte over the
// non-space key bytes, through one shared modular adder. It then probes the
// slot memory through its single read port, one slot a cycle: a hit ends the
// probe, a miss walks all TABLE_SIZE slots. An update state and a reply state
// follow. An insert into a full table, and a clear of an empty one, go
// straight to the reply state. A successful clear sweeps the whole memory
// and then replies. After reset the same sweep runs before the first word is
// taken. A finished reply waits in the output register; a new word is
// accepted meanwhile.
module word_count_hash_table
  import wcht_pkg::*;
#(
  parameter int TABLE_SIZE = 256,
  parameter int KEY_BYTES  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key[63:0], key_length[67:64], zero fill
  input  logic [OP_W-1:0]        in_tuser,   // operation[1:0]
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // slot[7:0], occurrences[23:8]
  output logic [STATUS_W-1:0]    out_tuser   // status[1:0]
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int KW = KEY_BYTES * 8;
  localparam int EW = $clog2(TABLE_SIZE + 1);

  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);
  localparam logic [EW-1:0] FULL_CNT  = EW'(TABLE_SIZE);

  // One table entry as held in the slot memory.
  typedef struct packed {
    logic                  used;
    logic [LEN_W-1:0]      len;
    logic [KW-1:0]         key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_UPDATE,
    S_REPLY
  } state_t;

  state_t                state_r;
  op_t                   op_r;
  logic [KW-1:0]         key_r;
  logic [LEN_W-1:0]      len_r;
  logic [IW-1:0]         pos_r;
  logic [IW-1:0]         chk_pos_r;
  logic                  chk_v_r;
  logic [EW-1:0]         issue_cnt_r;
  logic                  found_r;
  logic                  free_seen_r;
  logic [IW-1:0]         free_slot_r;
  logic [IW-1:0]         hit_slot_r;
  logic [COUNT_BITS-1:0] hit_count_r;
  logic [EW-1:0]         entries_r;
  logic [IW-1:0]         sweep_r;
  logic                  reply_r;
  status_t               res_status_r;
  logic [IW-1:0]         res_slot_r;
  logic [COUNT_BITS-1:0] res_occ_r;
  logic                  out_tvalid_r;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [OCC_W-1:0]      out_occ_r;

  entry_t mem [TABLE_SIZE];
  entry_t rd_entry_r;

  op_t                   in_op;
  logic [LEN_W-1:0]      in_len_raw;
  logic [LEN_W-1:0]      len_sat;
  logic [KW-1:0]         key_masked;
  logic                  in_accept;
  logic                  hash_start;
  logic                  hash_done;
  logic [IW-1:0]         hash_home;
  logic [IW-1:0]         next_pos;
  logic                  probe_hit;
  logic [COUNT_BITS-1:0] inc_count;
  logic [COUNT_BITS-1:0] dec_count;
  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  entry_t                mem_wdata;

  // Input decode: the length saturates at KEY_BYTES and key bytes past the
  // length are dropped, so stored keys compare as plain words.
  assign in_op      = op_t'(in_tuser);
  assign in_len_raw = in_tdata[KEY_W +: LEN_W];
  assign len_sat    = (in_len_raw > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_len_raw;

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? in_tdata[b*8 +: 8] : 8'h00;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Every operation but clear needs the home slot, except an insert that
  // already knows the table is full.
  assign hash_start = in_accept && (in_op != OP_CLEAR) &&
                      !((in_op == OP_INSERT) && (entries_r >= FULL_CNT));

  wcht_hash #(
    .TABLE_SIZE(TABLE_SIZE),
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (key_masked),
    .key_len(len_sat),
    .done   (hash_done),
    .home   (hash_home)
  );

  assign next_pos  = (pos_r == LAST_SLOT) ? '0 : pos_r + IW'(1);
  assign probe_hit = rd_entry_r.used && (rd_entry_r.len == len_r) && (rd_entry_r.key == key_r);
  assign inc_count = (&hit_count_r) ? hit_count_r : hit_count_r + COUNT_BITS'(1);
  assign dec_count = hit_count_r - COUNT_BITS'(1);

  // Memory write port: the sweep clears entries, the update cycle writes the
  // entry that the operation changed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = '0;
    unique case (state_r)
      S_SWEEP: begin
        mem_we = 1'b1;
      end
      S_UPDATE: begin
        unique case (op_r)
          OP_INSERT: begin
            mem_we         = 1'b1;
            mem_wdata.used = 1'b1;
            mem_wdata.len  = len_r;
            mem_wdata.key  = key_r;
            if (found_r) begin
              mem_waddr       = hit_slot_r;
              mem_wdata.count = inc_count;
            end else begin
              mem_waddr       = free_slot_r;
              mem_wdata.count = COUNT_BITS'(1);
            end
          end
          OP_DELETE: begin
            mem_waddr = hit_slot_r;
            if (found_r && (entries_r != '0)) begin
              mem_we = 1'b1;
              if (hit_count_r > COUNT_BITS'(1)) begin
                mem_wdata.used  = 1'b1;
                mem_wdata.len   = len_r;
                mem_wdata.key   = key_r;
                mem_wdata.count = dec_count;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write and one registered read a cycle. The read address
  // is the probe position.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      sweep_r      <= '0;
      reply_r      <= 1'b0;
      entries_r    <= '0;
      out_tvalid_r <= 1'b0;
      chk_v_r      <= 1'b0;
    end else begin
      // The reply state reloads the output register itself.
      if (out_tready && (state_r != S_REPLY)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_SWEEP: begin
          sweep_r <= sweep_r + IW'(1);
          if (sweep_r == LAST_SLOT) begin
            state_r <= reply_r ? S_REPLY : S_IDLE;
            reply_r <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r       <= in_op;
            key_r      <= key_masked;
            len_r      <= len_sat;
            res_slot_r <= '0;
            res_occ_r  <= '0;
            priority if (in_op == OP_CLEAR) begin
              if (entries_r == '0) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_REPLY;
              end else begin
                res_status_r <= ST_OK;
                entries_r    <= '0;
                sweep_r      <= '0;
                reply_r      <= 1'b1;
                state_r      <= S_SWEEP;
              end
            end else if ((in_op == OP_INSERT) && (entries_r >= FULL_CNT)) begin
              res_status_r <= ST_FULL;
              state_r      <= S_REPLY;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            pos_r       <= hash_home;
            issue_cnt_r <= '0;
            chk_v_r     <= 1'b0;
            found_r     <= 1'b0;
            free_seen_r <= 1'b0;
            state_r     <= S_PROBE;
          end
        end
        S_PROBE: begin
          // Issue one read a cycle; the data returns in the next cycle and is
          // checked against the key while the next read is under way.
          if (issue_cnt_r != FULL_CNT) begin
            pos_r       <= next_pos;
            issue_cnt_r <= issue_cnt_r + EW'(1);
            chk_v_r     <= 1'b1;
            chk_pos_r   <= pos_r;
          end else begin
            chk_v_r <= 1'b0;
          end
          if (chk_v_r && probe_hit) begin
            found_r     <= 1'b1;
            hit_slot_r  <= chk_pos_r;
            hit_count_r <= rd_entry_r.count;
            state_r     <= S_UPDATE;
          end else begin
            // The first unused slot from home is where a new key goes.
            if (chk_v_r && !rd_entry_r.used && !free_seen_r) begin
              free_seen_r <= 1'b1;
              free_slot_r <= chk_pos_r;
            end
            if (!chk_v_r && (issue_cnt_r == FULL_CNT)) begin
              state_r <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          state_r <= S_REPLY;
          unique case (op_r)
            OP_INSERT: begin
              res_status_r <= ST_OK;
              if (found_r) begin
                res_slot_r <= hit_slot_r;
                res_occ_r  <= inc_count;
              end else begin
                res_slot_r <= free_slot_r;
                res_occ_r  <= COUNT_BITS'(1);
                entries_r  <= entries_r + EW'(1);
              end
            end
            OP_SEARCH: begin
              if (found_r) begin
                res_status_r <= ST_OK;
                res_slot_r   <= hit_slot_r;
                res_occ_r    <= hit_count_r;
              end else begin
                res_status_r <= ST_NOT_FOUND;
              end
            end
            OP_DELETE: begin
              priority if (!found_r) begin
                res_status_r <= ST_NOT_FOUND;
              end else if (entries_r == '0) begin
                res_status_r <= ST_EMPTY;
              end else begin
                res_status_r <= ST_OK;
                res_slot_r   <= hit_slot_r;
                if (hit_count_r > COUNT_BITS'(1)) begin
                  res_occ_r <= dec_count;
                end else begin
                  res_occ_r <= '0;
                  entries_r <= entries_r - EW'(1);
                end
              end
            end
            default: begin
              res_status_r <= ST_OK;
            end
          endcase
        end
        S_REPLY: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= SLOT_W'(res_slot_r);
            out_occ_r    <= OCC_W'(res_occ_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_occ_r, out_slot_r};
  assign out_tuser  = out_status_r;

  // The table never holds more keys than it has slots.
  a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entries_r <= FULL_CNT)
    else $error("entry count exceeds table size");

  // A taken word always starts work, so the block drops ready at once.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("still ready after accepting a word");

  // A reply appears only out of the reply state.
  a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_REPLY))
    else $error("output word without a reply cycle");

  // The memory is only written by the sweep or an update.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == S_SWEEP) || (state_r == S_UPDATE)))
    else $error("slot memory written outside sweep or update");

endmodule

`default_nettype wire
